// File: sv/spiral_order_matrix_fill_assert.svh
// assertion macros shared by the spiral fill checker
`ifndef SPIRAL_ORDER_MATRIX_FILL_ASSERT_SVH
`define SPIRAL_ORDER_MATRIX_FILL_ASSERT_SVH

// same-cycle implication, off during reset
`define SOFM_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("spiral fill check failed");

// next-cycle implication, off during reset
`define SOFM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("spiral fill check failed");

// next-cycle implication that also holds across reset
`define SOFM_ASSERT_ALWAYS_NEXT(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("spiral fill check failed");

`endif

// File: sv/sofm_pkg.sv
// types, constants and helpers shared by the spiral fill modules
`timescale 1ns / 1ps

package sofm_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;

  // field and register widths
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int SIZE_W    = 6;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 2 * SIZE_W;
  localparam int PLACED_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int CELL_DEPTH = MAX_ROWS << COL_W;
  localparam int CFG_IDX_W = 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_PLACE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  // one classified operation, front to back
  typedef struct packed {
    logic               is_read;
    logic               read_hit;
    logic               placed;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } op_t;

  // what the output stage keeps of an operation
  typedef struct packed {
    logic             is_read;
    logic             read_hit;
    logic             placed;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } res_t;

  // size register as used: zero acts as one, above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// File: sv/sofm_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module sofm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sofm_queue.sv
// short fifo of classified operations between front and back
`timescale 1ns / 1ps

module sofm_queue
  import sofm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic q_valid,
  output op_t  q_op,
  input  logic q_pop
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr_next;

  // status
  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];

  // pointer wrap
  assign wr_ptr_next = (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr_next;
      if (q_pop) rd_ptr <= rd_ptr_next;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// File: sv/sofm_front.sv
// front end: size registers, spiral cursor, command decode and fill check
`timescale 1ns / 1ps

module sofm_front
  import sofm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           cmd,
  input  logic [DATA_W-1:0]    value,
  input  logic [ROW_W-1:0]     read_row,
  input  logic [COL_W-1:0]     read_col,
  input  logic                 queue_full,
  output logic                 push,
  output op_t                  push_op
);

  logic [SIZE_W-1:0]   row_count, row_count_next;
  logic [SIZE_W-1:0]   column_count, column_count_next;
  logic [ROW_W-1:0]    cursor_row, cursor_row_next;
  logic [COL_W-1:0]    cursor_col, cursor_col_next;
  logic [ROW_W-1:0]    bound_top, bound_top_next;
  logic [ROW_W-1:0]    bound_bottom, bound_bottom_next;
  logic [COL_W-1:0]    bound_left, bound_left_next;
  logic [COL_W-1:0]    bound_right, bound_right_next;
  heading_t            heading, heading_next;
  logic [PLACED_W-1:0] placed_total, placed_total_next;

  logic [SIZE_W-1:0] rows_used, cols_used;
  logic [SIZE_W-1:0] rows_new, cols_new;
  logic [CAP_W-1:0]  capacity;
  logic              full;
  logic              take;
  cmd_t              op_cmd;
  logic              do_place;
  logic              do_restart;
  logic              in_range;
  logic              in_rect;
  logic              leg_done;
  logic              visited;

  assign op_cmd     = cmd_t'(cmd);
  assign item_stall = queue_full;
  assign take       = item_valid && !queue_full;
  assign push       = take;

  // sizes in use and matrix capacity
  assign rows_used = clamp_size(row_count, SIZE_W'(MAX_ROWS));
  assign cols_used = clamp_size(column_count, SIZE_W'(MAX_COLS));
  assign capacity  = rows_used * cols_used;
  assign full      = (CAP_W'(placed_total) == capacity);

  assign do_place   = take && (op_cmd == CMD_PLACE) && !full;
  assign do_restart = cfg_write || (take && (op_cmd == CMD_RESTART));

  // register writes, each one rewinds the spiral
  assign row_count_next    = (cfg_write && cfg_index == REG_ROW_COUNT) ? cfg_data : row_count;
  assign column_count_next = (cfg_write && cfg_index == REG_COLUMN_COUNT) ? cfg_data
                                                                          : column_count;
  assign rows_new = clamp_size(row_count_next, SIZE_W'(MAX_ROWS));
  assign cols_new = clamp_size(column_count_next, SIZE_W'(MAX_COLS));

  // filled cells are everything outside the open rectangle plus the done part of this leg
  assign in_range = (SIZE_W'(read_row) < rows_used) && (SIZE_W'(read_col) < cols_used);
  assign in_rect  = (read_row >= bound_top) && (read_row <= bound_bottom) &&
                    (read_col >= bound_left) && (read_col <= bound_right);
  always_comb begin
    unique case (heading)
      HEAD_RIGHT: leg_done = (read_row == bound_top) && (read_col < cursor_col);
      HEAD_DOWN:  leg_done = (read_col == bound_right) && (read_row < cursor_row);
      HEAD_LEFT:  leg_done = (read_row == bound_bottom) && (read_col > cursor_col);
      HEAD_UP:    leg_done = (read_col == bound_left) && (read_row > cursor_row);
      default:    leg_done = 1'b0;
    endcase
  end
  assign visited = full || !in_rect || leg_done;

  // next state: restart, or step the cursor along the spiral
  always_comb begin
    cursor_row_next   = cursor_row;
    cursor_col_next   = cursor_col;
    bound_top_next    = bound_top;
    bound_bottom_next = bound_bottom;
    bound_left_next   = bound_left;
    bound_right_next  = bound_right;
    heading_next      = heading;
    placed_total_next = placed_total;
    priority if (do_restart) begin
      cursor_row_next   = '0;
      cursor_col_next   = '0;
      bound_top_next    = '0;
      bound_left_next   = '0;
      bound_bottom_next = ROW_W'(rows_new - 1'b1);
      bound_right_next  = COL_W'(cols_new - 1'b1);
      heading_next      = HEAD_RIGHT;
      placed_total_next = '0;
    end else if (do_place) begin
      placed_total_next = placed_total + 1'b1;
      unique case (heading)
        HEAD_RIGHT: begin
          if (cursor_col < bound_right) begin
            cursor_col_next = cursor_col + 1'b1;
          end else begin
            bound_top_next  = bound_top + 1'b1;
            heading_next    = HEAD_DOWN;
            cursor_row_next = cursor_row + 1'b1;
          end
        end
        HEAD_DOWN: begin
          if (cursor_row < bound_bottom) begin
            cursor_row_next = cursor_row + 1'b1;
          end else begin
            bound_right_next = bound_right - 1'b1;
            heading_next     = HEAD_LEFT;
            cursor_col_next  = cursor_col - 1'b1;
          end
        end
        HEAD_LEFT: begin
          if (cursor_col > bound_left) begin
            cursor_col_next = cursor_col - 1'b1;
          end else begin
            bound_bottom_next = bound_bottom - 1'b1;
            heading_next      = HEAD_UP;
            cursor_row_next   = cursor_row - 1'b1;
          end
        end
        HEAD_UP: begin
          if (cursor_row > bound_top) begin
            cursor_row_next = cursor_row - 1'b1;
          end else begin
            bound_left_next = bound_left + 1'b1;
            heading_next    = HEAD_RIGHT;
            cursor_col_next = cursor_col + 1'b1;
          end
        end
        default: begin
          heading_next = HEAD_RIGHT;
        end
      endcase
    end else begin
      heading_next = heading;
    end
  end

  // outputs: the classified operation for the back end
  always_comb begin
    push_op.is_read  = (op_cmd == CMD_READ);
    push_op.read_hit = (op_cmd == CMD_READ) && in_range && visited;
    push_op.placed   = do_place;
    push_op.addr     = do_place ? {cursor_row, cursor_col} : {read_row, read_col};
    push_op.value    = value;
    push_op.row      = do_place ? cursor_row : '0;
    push_op.col      = do_place ? cursor_col : '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= SIZE_W'(MAX_ROWS);
      column_count <= SIZE_W'(MAX_COLS);
      cursor_row   <= '0;
      cursor_col   <= '0;
      bound_top    <= '0;
      bound_left   <= '0;
      bound_bottom <= ROW_W'(MAX_ROWS - 1);
      bound_right  <= COL_W'(MAX_COLS - 1);
      heading      <= HEAD_RIGHT;
      placed_total <= '0;
    end else begin
      row_count    <= row_count_next;
      column_count <= column_count_next;
      cursor_row   <= cursor_row_next;
      cursor_col   <= cursor_col_next;
      bound_top    <= bound_top_next;
      bound_bottom <= bound_bottom_next;
      bound_left   <= bound_left_next;
      bound_right  <= bound_right_next;
      heading      <= heading_next;
      placed_total <= placed_total_next;
    end
  end

endmodule

// File: sv/sofm_back.sv
// back end: cell memory access and the result register
`timescale 1ns / 1ps

module sofm_back
  import sofm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  op_t                      q_op,
  output logic                     q_pop,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] cell_value,
  output logic                     placed,
  output logic [ROW_W-1:0]         placed_row,
  output logic [COL_W-1:0]         placed_col
);

  logic              advance;
  res_t              res;
  logic [DATA_W-1:0] rdata;

  // move on when the result slot is free or being taken
  assign advance = !result_valid || !result_stall;
  assign q_pop   = q_valid && advance;

  sofm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELL_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (q_pop && q_op.placed),
    .waddr (q_op.addr),
    .wdata (q_op.value),
    .re    (q_pop && q_op.read_hit),
    .raddr (q_op.addr),
    .rdata (rdata)
  );

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.is_read  <= q_op.is_read;
      res.read_hit <= q_op.read_hit;
      res.placed   <= q_op.placed;
      res.row      <= q_op.row;
      res.col      <= q_op.col;
    end
  end

  // result fields
  always_comb begin
    if (!res.is_read) cell_value = '0;
    else if (res.read_hit) cell_value = rdata;
    else cell_value = EMPTY_VALUE;
  end
  assign placed     = res.placed;
  assign placed_row = res.row;
  assign placed_col = res.col;

endmodule

// File: sv/spiral_order_matrix_fill.sv
// top level of the spiral-order matrix fill block
`timescale 1ns / 1ps

// Accepts one command per cycle while item_stall is low and gives one result
// per command, in order. A place writes its value at the next cell of the
// clockwise spiral from the top-left and reports that cell; once all
// row_count x column_count cells are filled it reports not placed. A read
// returns the cell, or -1 for an empty or out-of-size cell; a restart (and any
// register write) rewinds the spiral and empties the matrix at once, with no
// clearing pass: a cell counts as filled from the cursor position and spiral
// bounds. Sustained rate is one item per cycle while result_stall is low, each
// item using the write or the read port of the 1024 x 32 cell memory; a command
// passes the four-entry operation queue, then the registered memory read.
module spiral_order_matrix_fill
  import sofm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SIZE_W-1:0]        cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] value,
  input  logic [ROW_W-1:0]         read_row,
  input  logic [COL_W-1:0]         read_col,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] cell_value,
  output logic                     placed,
  output logic [ROW_W-1:0]         placed_row,
  output logic [COL_W-1:0]         placed_col
);

  logic push;
  op_t  push_op;
  logic queue_full;
  logic q_valid;
  op_t  q_op;
  logic q_pop;

  // command decode and spiral tracking
  sofm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .value      (value),
    .read_row   (read_row),
    .read_col   (read_col),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  // operation queue
  sofm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (queue_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  // memory and results
  sofm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_value   (cell_value),
    .placed       (placed),
    .placed_row   (placed_row),
    .placed_col   (placed_col)
  );

endmodule

// File: sv/sofm_checker.sv
// port-level checks for the spiral fill block, bound to the top level
`timescale 1ns / 1ps
`include "spiral_order_matrix_fill_assert.svh"

module sofm_checker
  import sofm_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     item_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic signed [DATA_W-1:0] cell_value,
  input logic                     placed,
  input logic [ROW_W-1:0]         placed_row,
  input logic [COL_W-1:0]         placed_col
);

  logic [DATA_W+ROW_W+COL_W:0] outs;
  logic [ROW_W+COL_W-1:0]      pos;

  // result fields gathered for the checks below
  assign outs = {cell_value, placed, placed_row, placed_col};
  assign pos  = {placed_row, placed_col};

  // a stalled result transfer keeps its fields
  `SOFM_ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(outs))

  // a placed value never comes with read data
  `SOFM_ASSERT_IMPLY(a_place_no_data, clk, rst, result_valid && placed, cell_value == 0)

  // no position without a placement
  `SOFM_ASSERT_IMPLY(a_no_place_pos, clk, rst, result_valid && !placed, pos == 0)

  // reset empties the pipeline
  `SOFM_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !result_valid && !item_stall)

endmodule

bind spiral_order_matrix_fill sofm_checker u_checker (.*);

// File: dv/tb_spiral_order_matrix_fill.sv
// testbench for the spiral-order matrix fill block
`timescale 1ns / 1ps

module tb_spiral_order_matrix_fill;
  import sofm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int CELL_COUNT   = MAX_ROWS * MAX_COLS;

  // one result of the block as seen on its outputs
  typedef struct packed {
    logic [DATA_W-1:0] cell_value;
    logic              placed;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cell_result_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index    = '0;
  logic [SIZE_W-1:0]        cfg_data     = '0;
  logic                     item_valid   = 1'b0;
  logic                     item_stall;
  logic [1:0]               cmd          = '0;
  logic signed [DATA_W-1:0] value        = '0;
  logic [ROW_W-1:0]         read_row     = '0;
  logic [COL_W-1:0]         read_col     = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DATA_W-1:0] cell_value;
  logic                     placed;
  logic [ROW_W-1:0]         placed_row;
  logic [COL_W-1:0]         placed_col;

  // matrix mirror and spiral walker state
  logic [DATA_W-1:0] mirror_store [CELL_COUNT];
  bit                mirror_filled [CELL_COUNT];
  logic [SIZE_W-1:0] rows_reg;
  logic [SIZE_W-1:0] cols_reg;
  int                cur_row;
  int                cur_col;
  int                lim_top;
  int                lim_bottom;
  int                lim_left;
  int                lim_right;
  heading_t          walk_dir;
  int                fill_count;

  cell_result_t pending_results[$];

  int gap_pct        = 13;
  int stall_pct      = 52;
  int mismatch_count = 0;
  int cycle_count    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spiral_order_matrix_fill DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .value        (value),
    .read_row     (read_row),
    .read_col     (read_col),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_value   (cell_value),
    .placed       (placed),
    .placed_row   (placed_row),
    .placed_col   (placed_col)
  );

  // size register as the block uses it
  function automatic int used_size(input logic [SIZE_W-1:0] raw, input int limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // empty the matrix and put the walker back at the top-left
  function automatic void rewind_spiral();
    foreach (mirror_filled[i]) mirror_filled[i] = 1'b0;
    cur_row    = 0;
    cur_col    = 0;
    lim_top    = 0;
    lim_left   = 0;
    lim_bottom = used_size(rows_reg, MAX_ROWS) - 1;
    lim_right  = used_size(cols_reg, MAX_COLS) - 1;
    walk_dir   = HEAD_RIGHT;
    fill_count = 0;
  endfunction

  // one clockwise step, turning and shrinking the bound at each corner
  function automatic void step_spiral();
    case (walk_dir)
      HEAD_RIGHT: begin
        if (cur_col < lim_right) cur_col++;
        else begin
          lim_top++;
          walk_dir = HEAD_DOWN;
          cur_row++;
        end
      end
      HEAD_DOWN: begin
        if (cur_row < lim_bottom) cur_row++;
        else begin
          lim_right--;
          walk_dir = HEAD_LEFT;
          cur_col--;
        end
      end
      HEAD_LEFT: begin
        if (cur_col > lim_left) cur_col--;
        else begin
          lim_bottom--;
          walk_dir = HEAD_UP;
          cur_row--;
        end
      end
      default: begin
        if (cur_row > lim_top) cur_row--;
        else begin
          lim_left++;
          walk_dir = HEAD_RIGHT;
          cur_col++;
        end
      end
    endcase
  endfunction

  // expected result of one command, updating the mirror
  function automatic cell_result_t compute_cell_result(input cmd_t c,
                                                       input logic [DATA_W-1:0] v,
                                                       input logic [ROW_W-1:0] rr,
                                                       input logic [COL_W-1:0] rc);
    cell_result_t r;
    int nr;
    int nc;
    r  = '0;
    nr = used_size(rows_reg, MAX_ROWS);
    nc = used_size(cols_reg, MAX_COLS);
    case (c)
      CMD_PLACE: begin
        if (fill_count < nr * nc && cur_row >= 0 && cur_col >= 0 &&
            cur_row < nr && cur_col < nc) begin
          mirror_store[cur_row * MAX_COLS + cur_col]  = v;
          mirror_filled[cur_row * MAX_COLS + cur_col] = 1'b1;
          r.placed = 1'b1;
          r.row    = cur_row[ROW_W-1:0];
          r.col    = cur_col[COL_W-1:0];
          fill_count++;
          step_spiral();
        end
      end
      CMD_READ: begin
        r.cell_value = EMPTY_VALUE;
        if (rr < nr && rc < nc && mirror_filled[rr * MAX_COLS + rc])
          r.cell_value = mirror_store[rr * MAX_COLS + rc];
      end
      CMD_RESTART: rewind_spiral();
      default: ;
    endcase
    return r;
  endfunction

  // mostly random data, now and then an extreme
  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly small sizes, some full size, some needing the clamp
  function automatic logic [SIZE_W-1:0] random_size();
    int p;
    p = $urandom_range(99);
    if (p < 4) return '0;
    if (p < 9) return SIZE_W'($urandom_range(33, 63));
    if (p < 16) return SIZE_W'(32);
    if (p < 24) return SIZE_W'($urandom_range(8, 31));
    return SIZE_W'($urandom_range(1, 7));
  endfunction

  task automatic report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // result port stalls at random
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    cell_result_t want;
    cell_result_t got;
    if (!rst && result_valid && !result_stall) begin
      got = {cell_value, placed, placed_row, placed_col};
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result value %h placed %b at (%0d,%0d)",
                                 got.cell_value, got.placed, got.row, got.col));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          report_failure($sformatf(
            "expected value %h placed %b at (%0d,%0d), got value %h placed %b at (%0d,%0d)",
            want.cell_value, want.placed, want.row, want.col,
            got.cell_value, got.placed, got.row, got.col));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one item transfer, with random gaps in front of it
  task automatic send_item(input cmd_t c, input logic [DATA_W-1:0] v,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    value      <= v;
    read_row   <= rr;
    read_col   <= rc;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(compute_cell_result(c, v, rr, rc));
  endtask

  task automatic place_value(input logic [DATA_W-1:0] v);
    send_item(CMD_PLACE, v, ROW_W'($urandom_range(31)), COL_W'($urandom_range(31)));
  endtask

  task automatic wait_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle; it also rewinds the spiral
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    wait_until_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_reg = data;
    else cols_reg = data;
    rewind_spiral();
  endtask

  // first ring legs at the reset size, then a whole 32 x 4 spiral
  // with overflow and corner reads
  task automatic test_full_matrix();
    for (int i = 0; i < 40; i++) place_value(random_value());
    send_item(CMD_READ, '0, 5'd0, 5'd31);
    send_item(CMD_READ, '0, 5'd8, 5'd31);
    send_item(CMD_READ, '0, 5'd9, 5'd31);
    write_size(REG_COLUMN_COUNT, 6'd4);
    for (int i = 0; i < MAX_ROWS * 4; i++) place_value(random_value());
    place_value(32'h1234_5678);
    place_value(32'hFFFF_FFFF);
    send_item(CMD_READ, '0, 5'd0, 5'd0);
    send_item(CMD_READ, '0, 5'd0, 5'd3);
    send_item(CMD_READ, '0, 5'd31, 5'd0);
    send_item(CMD_READ, '0, 5'd31, 5'd3);
    send_item(CMD_READ, '0, 5'd16, 5'd2);
    send_item(CMD_READ, '0, 5'd5, 5'd4);
  endtask

  // 2 x 3 spiral with extreme data, overflow and out-of-size reads
  task automatic test_small_spiral();
    write_size(REG_ROW_COUNT, 6'd2);
    write_size(REG_COLUMN_COUNT, 6'd3);
    place_value(32'h8000_0000);
    place_value(32'h7FFF_FFFF);
    place_value(32'h0000_0000);
    place_value(32'hFFFF_FFFF);
    place_value(32'h5A5A_A5A5);
    place_value(32'hA5A5_5A5A);
    place_value(32'hDEAD_BEEF);
    send_item(CMD_READ, '0, 5'd1, 5'd2);
    send_item(CMD_READ, '0, 5'd2, 5'd0);
    send_item(CMD_READ, '0, 5'd0, 5'd31);
  endtask

  // restart clears the marks; unused command gives an all-zero result
  task automatic test_restart_and_nop();
    send_item(CMD_RESTART, 32'hFFFF_FFFF, 5'd31, 5'd31);
    send_item(CMD_READ, '0, 5'd0, 5'd0);
    send_item(CMD_NOP, 32'hFFFF_FFFF, 5'd31, 5'd31);
    place_value(32'h0BAD_F00D);
  endtask

  // zero rows acts as one, 63 columns acts as 32
  task automatic test_size_clamp();
    write_size(REG_ROW_COUNT, 6'd0);
    write_size(REG_COLUMN_COUNT, 6'd63);
    place_value(random_value());
    place_value(random_value());
    send_item(CMD_READ, '0, 5'd0, 5'd1);
    send_item(CMD_READ, '0, 5'd0, 5'd31);
    send_item(CMD_READ, '0, 5'd31, 5'd0);
  endtask

  // one column: the ring collapses right away, each cell once
  task automatic test_single_column();
    write_size(REG_ROW_COUNT, 6'd3);
    write_size(REG_COLUMN_COUNT, 6'd1);
    for (int i = 0; i < 4; i++) place_value(random_value());
  endtask

  // rounds of size setting, spiral fill with reads, restarts and noise
  task automatic test_random_spirals(input int target, input int gap, input int stall);
    int                sent;
    int                used_r;
    int                used_c;
    int                cap;
    int                n_place;
    int                k;
    logic [SIZE_W-1:0] raw_r;
    logic [SIZE_W-1:0] raw_c;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    logic [ADDR_W-1:0] round_cells[$];
    logic [ADDR_W-1:0] pick;
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < target) begin
      raw_r = random_size();
      raw_c = random_size();
      write_size(REG_ROW_COUNT, raw_r);
      write_size(REG_COLUMN_COUNT, raw_c);
      used_r  = used_size(raw_r, MAX_ROWS);
      used_c  = used_size(raw_c, MAX_COLS);
      cap     = used_r * used_c;
      n_place = (cap <= 48) ? cap + $urandom_range(2) : $urandom_range(8, 48);
      round_cells.delete();
      for (int i = 0; i < n_place; i++) begin
        if (fill_count < cap) round_cells.push_back({cur_row[ROW_W-1:0], cur_col[COL_W-1:0]});
        place_value(random_value());
        sent++;
        k = $urandom_range(99);
        if (k < 35) begin
          // read a filled cell, an in-size cell, an out-of-size cell or anything
          k = $urandom_range(9);
          if (k < 5 && round_cells.size() > 0) begin
            pick = round_cells[$urandom_range(round_cells.size() - 1)];
            rr   = pick[ADDR_W-1:COL_W];
            rc   = pick[COL_W-1:0];
          end else if (k < 7) begin
            rr = ROW_W'($urandom_range(used_r - 1));
            rc = COL_W'($urandom_range(used_c - 1));
          end else if (k < 9 && used_r < MAX_ROWS &&
                       (used_c == MAX_COLS || $urandom_range(1))) begin
            rr = ROW_W'($urandom_range(used_r, 31));
            rc = COL_W'($urandom_range(31));
          end else if (k < 9 && used_c < MAX_COLS) begin
            rr = ROW_W'($urandom_range(31));
            rc = COL_W'($urandom_range(used_c, 31));
          end else begin
            rr = ROW_W'($urandom_range(31));
            rc = COL_W'($urandom_range(31));
          end
          send_item(CMD_READ, random_value(), rr, rc);
          sent++;
        end else if (k < 39) begin
          send_item(CMD_RESTART, random_value(), ROW_W'($urandom_range(31)),
                    COL_W'($urandom_range(31)));
          round_cells.delete();
          sent++;
        end else if (k < 42) begin
          send_item(CMD_NOP, random_value(), ROW_W'($urandom_range(31)),
                    COL_W'($urandom_range(31)));
        end
      end
    end
  endtask

  initial begin
    rows_reg = SIZE_W'(MAX_ROWS);
    cols_reg = SIZE_W'(MAX_COLS);
    rewind_spiral();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_full_matrix();
    test_small_spiral();
    test_restart_and_nop();
    test_size_clamp();
    test_single_column();
    test_random_spirals(90, 13, 52);
    test_random_spirals(90, 52, 13);
    test_random_spirals(90, 0, 0);

    wait_until_drained();
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/sofm_pkg.sv
sv/sofm_ram.sv
sv/sofm_queue.sv
sv/sofm_front.sv
sv/sofm_back.sv
sv/spiral_order_matrix_fill.sv
sv/sofm_checker.sv
dv/tb_spiral_order_matrix_fill.sv
